### hw/rtl/bcrm_pkg.sv
// Shared types, opcodes and constants for the byte code register machine.
`default_nettype none

package bcrm_pkg;

    localparam int DEF_PROGRAM_DEPTH = 256;
    localparam int DEF_REG_WIDTH     = 32;
    localparam int REG_COUNT         = 16;
    localparam int RIDX_W            = $clog2(REG_COUNT);
    localparam int PC_W              = 8;
    localparam int LEN_W             = 9;
    localparam int BYTE_W            = 8;
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [7:0] {
        OP_INC  = 8'h01,
        OP_DEC  = 8'h02,
        OP_MOV  = 8'h03,
        OP_LDI  = 8'h04,
        OP_SHL  = 8'h05,
        OP_SHR  = 8'h06,
        OP_JMP  = 8'h07,
        OP_JEND = 8'h0A,
        OP_HALT = 8'h0B,
        OP_ADD  = 8'h0C,
        OP_SUB  = 8'h0D,
        OP_XOR  = 8'h0E,
        OP_OR   = 8'h0F,
        OP_IN   = 8'h10,
        OP_OUT  = 8'h11
    } opcode_t;

    typedef struct packed {
        logic accept;
        logic red_start;
        logic fetch_op;
        logic fetch_arg;
        logic read_regs;
        logic exec;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic step_req;
        logic stopped;
        logic pc_ge_len;
        logic jump_taken;
        logic rem_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/bcrm_rem.sv
// Restoring remainder unit, one dividend bit per cycle, for pc wrap and jump targets.
`default_nettype none

module bcrm_rem
    import bcrm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [LEN_W-1:0] dividend,
    input  wire logic [LEN_W-1:0] divisor,
    output logic                  done,
    output logic [PC_W-1:0]       rem
);

    localparam int CNT_W = $clog2(LEN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEN_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LEN_W-1:0] div_reg;
    logic [PC_W-1:0]  rem_reg;
    logic [LEN_W-1:0] part;
    logic [LEN_W-1:0] diff;
    logic [PC_W-1:0]  rem_next;

    always_comb begin
        part     = {rem_reg, div_reg[LEN_W-1]};
        diff     = part - divisor;
        rem_next = (part >= divisor) ? diff[PC_W-1:0] : part[PC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            div_reg <= {div_reg[LEN_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/bcrm_ctrl.sv
// Instruction sequencer state machine for the byte code register machine.
`default_nettype none

module bcrm_ctrl
    import bcrm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RED  = 8'b0000_0010,
        S_FOP  = 8'b0000_0100,
        S_FARG = 8'b0000_1000,
        S_RREG = 8'b0001_0000,
        S_EXEC = 8'b0010_0000,
        S_JMP  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_ready && s_valid;

    always_comb begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.red_start = accept && status.step_req && !status.stopped && status.pc_ge_len;
        cmd.fetch_op  = (state_reg == S_FOP);
        cmd.fetch_arg = (state_reg == S_FARG);
        cmd.read_regs = (state_reg == S_RREG);
        cmd.exec      = (state_reg == S_EXEC);
        cmd.out_load  = (state_reg == S_DONE) && !status.out_busy;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!status.step_req || status.stopped) begin
                        state_next = S_DONE;
                    end else if (status.pc_ge_len) begin
                        state_next = S_RED;
                    end else begin
                        state_next = S_FOP;
                    end
                end
            end
            S_RED: begin
                if (status.rem_done) begin
                    state_next = S_FOP;
                end
            end
            S_FOP:  state_next = S_FARG;
            S_FARG: state_next = S_RREG;
            S_RREG: state_next = S_EXEC;
            S_EXEC: begin
                state_next = status.jump_taken ? S_JMP : S_DONE;
            end
            S_JMP: begin
                if (status.rem_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_red_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RED) && !status.rem_done |=> (state_reg == S_RED))
        else $error("pc reduction left before the remainder finished");
    a_exec_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> !cmd.exec)
        else $error("instruction executed twice");
`endif

endmodule

`default_nettype wire

### hw/rtl/bcrm_dp.sv
// Datapath: program memory, register file, pc, execute logic and result register.
`default_nettype none

module bcrm_dp
    import bcrm_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int REG_WIDTH     = DEF_REG_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,
    input  wire logic              s_kind,
    input  wire logic [BYTE_W-1:0] s_address,
    input  wire logic [BYTE_W-1:0] s_value,
    input  wire logic [BYTE_W-1:0] s_in_byte,
    input  wire logic              s_in_end,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_out_valid,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_took_input,
    output logic                   m_halted,
    output logic [PC_W-1:0]        m_next_pc,
    input  wire ctrl_cmd_t         cmd,
    output dp_status_t             status
);

    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PROGRAM_DEPTH);

    logic [BYTE_W-1:0]    prog_mem [PROGRAM_DEPTH];
    logic [REG_WIDTH-1:0] rf_mem   [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic [LEN_W-1:0]     len_reg;
    logic [PC_W-1:0]      pc_reg;
    logic                 stopped_reg;
    logic                 ended_reg;
    logic [BYTE_W-1:0]    mem_rdata_reg;
    logic [BYTE_W-1:0]    op_reg;
    logic [BYTE_W-1:0]    arg_reg;
    logic [REG_WIDTH-1:0] x_reg;
    logic [REG_WIDTH-1:0] y_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_end_reg;

    logic                 res_outv_reg;
    logic [BYTE_W-1:0]    res_byte_reg;
    logic                 res_took_reg;

    logic                 m_valid_reg;
    logic                 m_out_valid_reg;
    logic [BYTE_W-1:0]    m_out_byte_reg;
    logic                 m_took_input_reg;
    logic                 m_halted_reg;
    logic [PC_W-1:0]      m_next_pc_reg;

    logic [LEN_W-1:0]     len_next;
    logic [LEN_W-1:0]     pc_inc1;
    logic [LEN_W-1:0]     pc_inc2;
    logic [LEN_W-1:0]     pc_wrap2;
    logic [PC_W-1:0]      pc1;
    logic [PC_W-1:0]      npc_seq;
    logic [PC_W-1:0]      rd_addr;
    logic [RIDX_W-1:0]    rd_x;
    logic [RIDX_W-1:0]    rd_y;
    logic [RIDX_W-1:0]    rx;
    logic                 jump_taken;

    logic                 rf_we;
    logic [RIDX_W-1:0]    rf_widx;
    logic [REG_WIDTH-1:0] rf_wdata;
    logic                 halt_set;
    logic                 ended_set;
    logic                 took;
    logic                 outv;

    logic                 rem_start;
    logic [LEN_W-1:0]     rem_dividend;
    logic                 rem_done;
    logic [PC_W-1:0]      rem_q;

    always_comb begin
        if (cfg_wr_data < LEN_MIN) begin
            len_next = LEN_MIN;
        end else if (cfg_wr_data > LEN_MAX) begin
            len_next = LEN_MAX;
        end else begin
            len_next = cfg_wr_data;
        end
    end

    always_comb begin
        pc_inc1  = {1'b0, pc_reg} + LEN_W'(1);
        pc_inc2  = {1'b0, pc_reg} + LEN_W'(2);
        pc_wrap2 = pc_inc2 - len_reg;
        pc1      = (pc_inc1 == len_reg) ? '0 : pc_inc1[PC_W-1:0];
        npc_seq  = (pc_inc2 >= len_reg) ? pc_wrap2[PC_W-1:0] : pc_inc2[PC_W-1:0];
        rd_addr  = cmd.fetch_arg ? pc1 : pc_reg;
        rd_x     = mem_rdata_reg[RIDX_W-1:0];
        rd_y     = mem_rdata_reg[BYTE_W-1:RIDX_W];
        rx       = arg_reg[RIDX_W-1:0];
        jump_taken = (op_reg == OP_JMP) || ((op_reg == OP_JEND) && ended_reg);
    end

    always_comb begin
        rf_we     = 1'b0;
        rf_widx   = rx;
        rf_wdata  = x_reg;
        halt_set  = 1'b0;
        ended_set = 1'b0;
        took      = 1'b0;
        outv      = 1'b0;
        unique case (op_reg)
            OP_INC: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg + REG_WIDTH'(1);
            end
            OP_DEC: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg - REG_WIDTH'(1);
            end
            OP_MOV: begin
                rf_we    = 1'b1;
                rf_wdata = y_reg;
            end
            OP_LDI: begin
                rf_we    = 1'b1;
                rf_widx  = '0;
                rf_wdata = REG_WIDTH'(arg_reg);
            end
            OP_SHL: begin
                rf_we    = 1'b1;
                rf_wdata = {x_reg[REG_WIDTH-2:0], 1'b0};
            end
            OP_SHR: begin
                rf_we    = 1'b1;
                rf_wdata = {x_reg[REG_WIDTH-1], x_reg[REG_WIDTH-1:1]};
            end
            OP_HALT: halt_set = 1'b1;
            OP_ADD: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg + y_reg;
            end
            OP_SUB: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg - y_reg;
            end
            OP_XOR: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg ^ y_reg;
            end
            OP_OR: begin
                rf_we    = 1'b1;
                rf_wdata = x_reg | y_reg;
            end
            OP_IN: begin
                if (in_end_reg) begin
                    ended_set = 1'b1;
                end else begin
                    rf_we    = 1'b1;
                    rf_wdata = REG_WIDTH'(in_byte_reg);
                    took     = 1'b1;
                end
            end
            OP_OUT: outv = 1'b1;
            default: ;
        endcase
    end

    assign rem_start    = cmd.red_start || (cmd.exec && jump_taken);
    assign rem_dividend = cmd.red_start ? {1'b0, pc_reg}
                                        : ({1'b0, pc_reg} + {1'b0, arg_reg});

    bcrm_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (len_reg),
        .done     (rem_done),
        .rem      (rem_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_kind == KIND_WRITE) && ({1'b0, s_address} < LEN_MAX)) begin
            prog_mem[s_address[AW-1:0]] <= s_value;
        end
        if (cmd.fetch_op || cmd.fetch_arg) begin
            mem_rdata_reg <= prog_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && rf_we) begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (cmd.read_regs) begin
            x_reg <= rf_valid_reg[rd_x] ? rf_mem[rd_x] : '0;
            y_reg <= rf_valid_reg[rd_y] ? rf_mem[rd_y] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_in_end;
        end
        if (cmd.fetch_arg) begin
            op_reg <= mem_rdata_reg;
        end
        if (cmd.read_regs) begin
            arg_reg <= mem_rdata_reg;
        end
        if (cmd.out_load) begin
            m_out_valid_reg  <= res_outv_reg;
            m_out_byte_reg   <= res_byte_reg;
            m_took_input_reg <= res_took_reg;
            m_halted_reg     <= stopped_reg;
            m_next_pc_reg    <= pc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_MAX;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            ended_reg    <= 1'b0;
            rf_valid_reg <= '0;
            res_outv_reg <= 1'b0;
            res_byte_reg <= '0;
            res_took_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= len_next;
            end
            if (cmd.accept) begin
                res_outv_reg <= 1'b0;
                res_byte_reg <= '0;
                res_took_reg <= 1'b0;
            end
            if (rem_done) begin
                pc_reg <= rem_q;
            end
            if (cmd.exec) begin
                res_outv_reg <= outv;
                res_byte_reg <= outv ? x_reg[BYTE_W-1:0] : '0;
                res_took_reg <= took;
                if (rf_we) begin
                    rf_valid_reg[rf_widx] <= 1'b1;
                end
                if (halt_set) begin
                    stopped_reg <= 1'b1;
                end
                if (ended_set) begin
                    ended_reg <= 1'b1;
                end
                if (!jump_taken && !halt_set) begin
                    pc_reg <= npc_seq;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status            = '0;
        status.step_req   = (s_kind == KIND_STEP);
        status.stopped    = stopped_reg;
        status.pc_ge_len  = ({1'b0, pc_reg} >= len_reg);
        status.jump_taken = jump_taken;
        status.rem_done   = rem_done;
        status.out_busy   = m_valid_reg && !m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_valid  = m_out_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_took_input = m_took_input_reg;
    assign m_halted     = m_halted_reg;
    assign m_next_pc    = m_next_pc_reg;

`ifndef NO_ASSERTIONS
    a_fetch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch_op |-> ({1'b0, pc_reg} < len_reg))
        else $error("opcode fetch with pc outside program length");
    a_rem_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |=> ({1'b0, pc_reg} < len_reg))
        else $error("wrapped pc not below program length");
    a_stop_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("halt state cleared without reset");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register loaded while a transaction is pending");
`endif

endmodule

`default_nettype wire

### hw/rtl/byte_code_register_machine.sv
// Top level of the byte code register machine: sequencer plus datapath.
//
// Input channel (s_valid/s_ready): each transaction is either a program byte
// write (s_kind = 0, s_value stored at s_address) or one instruction step
// (s_kind = 1, s_in_byte/s_in_end offered to a read instruction).
// Result channel (m_valid/m_ready): exactly one result per input transaction,
// in order, carrying output byte, input-taken flag, halt state and next pc.
// cfg_wr_en/cfg_wr_data set the program length, saturated into 2..depth.
// A program write or a step while halted goes from accept straight to the
// result load. A step runs opcode read, operand read, register file read,
// execute and result load. A taken jump adds a pass through the serial
// remainder unit that wraps the target modulo the length; a step whose pc lies
// beyond a newly shortened length adds another pass for the same wrap.
// The block takes one transaction at a time; s_ready is high only between items.
// A finished result sits in the output register while the next item runs; if
// the receiver stalls, the block holds the following result until it is free.
// Reset clears registers, pc, halt and end-of-input state and sets the length
// to the full depth; the program memory holds no reset value.
`default_nettype none

module byte_code_register_machine
    import bcrm_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int REG_WIDTH     = DEF_REG_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_kind,
    input  wire logic [BYTE_W-1:0] s_address,
    input  wire logic [BYTE_W-1:0] s_value,
    input  wire logic [BYTE_W-1:0] s_in_byte,
    input  wire logic              s_in_end,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_out_valid,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_took_input,
    output logic                   m_halted,
    output logic [PC_W-1:0]        m_next_pc
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bcrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bcrm_dp #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .REG_WIDTH     (REG_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_kind       (s_kind),
        .s_address    (s_address),
        .s_value      (s_value),
        .s_in_byte    (s_in_byte),
        .s_in_end     (s_in_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_valid  (m_out_valid),
        .m_out_byte   (m_out_byte),
        .m_took_input (m_took_input),
        .m_halted     (m_halted),
        .m_next_pc    (m_next_pc),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
